// ===== design/lpht_pkg.sv =====
// Shared types and constants for the linear probe hash table.
// Used by every module of the block but lpht_ram; depends on nothing.
`default_nettype none
package lpht_pkg;

	localparam int TABLE_SIZE = 13;
	localparam int KEY_WIDTH  = 32;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int REM_W      = $clog2(TABLE_SIZE);
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = 4;
	localparam int KEY_IN_W   = 32;
	localparam int S_DATA_W   = ((CMD_W + KEY_IN_W + 7) / 8) * 8;
	localparam int M_DATA_W   = ((STATUS_W + SLOT_W + 7) / 8) * 8;

	localparam int HCHUNK_N  = (KEY_WIDTH + 7) / 8;
	localparam int HSUM_W    = 8 + IDX_W + $clog2(HCHUNK_N);
	localparam int HRECIP_SH = HSUM_W + IDX_W;
	localparam int HPROD_W   = HSUM_W + HRECIP_SH;
	localparam logic [HPROD_W-1:0] HRECIP_M =
		HPROD_W'(((longint'(1) << HRECIP_SH) + TABLE_SIZE - 1) / TABLE_SIZE);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_READ,
		S_CHECK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] rem;
	} hash_rsp_t;

	typedef struct packed {
		logic                 re;
		logic                 we;
		logic [IDX_W-1:0]     addr;
		logic [KEY_WIDTH-1:0] wdata;
	} ram_req_t;

	// weight of key byte n: 256**n mod TABLE_SIZE
	function automatic logic [HSUM_W-1:0] chunk_weight(input int n);
		int w;
		w = 1 % TABLE_SIZE;
		for (int i = 0; i < n; i++) begin
			w = (w * 256) % TABLE_SIZE;
		end
		return HSUM_W'(w);
	endfunction

endpackage
`default_nettype wire

// ===== design/lpht_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== design/lpht_hash.sv =====
// Remainder unit: key mod TABLE_SIZE, pipelined (weighted byte fold into a registered sum,
// then reciprocal multiply and subtract into the registered remainder). Depends on lpht_pkg.
`default_nettype none
module lpht_hash (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [lpht_pkg::KEY_WIDTH-1:0] key,
	output lpht_pkg::hash_rsp_t                 rsp
);

	logic [lpht_pkg::HCHUNK_N*8-1:0] key_pad;
	logic [lpht_pkg::HSUM_W-1:0]     part [lpht_pkg::HCHUNK_N];
	logic [lpht_pkg::HSUM_W-1:0]     sum;
	logic [lpht_pkg::HSUM_W-1:0]     sum_s1;
	logic                            vld_s1;
	logic [lpht_pkg::HPROD_W-1:0]    prod;
	logic [lpht_pkg::HSUM_W-1:0]     quot;
	logic [lpht_pkg::HSUM_W-1:0]     rem_full;
	logic [lpht_pkg::REM_W-1:0]      rem_q;
	logic                            done_q;

	assign key_pad = (lpht_pkg::HCHUNK_N*8)'(key);

	for (genvar g = 0; g < lpht_pkg::HCHUNK_N; g++) begin : g_chunk
		assign part[g] = lpht_pkg::HSUM_W'(key_pad[8*g +: 8]) * lpht_pkg::chunk_weight(g);
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < lpht_pkg::HCHUNK_N; i++) begin
			sum = sum + part[i];
		end
	end

	assign prod     = lpht_pkg::HPROD_W'(sum_s1) * lpht_pkg::HRECIP_M;
	assign quot     = prod[lpht_pkg::HPROD_W-1 -: lpht_pkg::HSUM_W];
	assign rem_full = sum_s1 - quot * lpht_pkg::HSUM_W'(lpht_pkg::TABLE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_s1 <= sum;
		end
		if (vld_s1) begin
			rem_q <= rem_full[lpht_pkg::REM_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

// ===== design/lpht_ctrl.sv =====
// Command sequencer: probes and scans the slot RAM, tracks slot occupancy, holds the result word.
// Depends on lpht_pkg; drives lpht_ram and lpht_hash through the top level.
`default_nettype none
module lpht_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [lpht_pkg::CMD_W-1:0]     cmd_in,
	input  wire logic [lpht_pkg::KEY_WIDTH-1:0] key_in,
	output logic                                hash_start,
	input  wire lpht_pkg::hash_rsp_t            hash_rsp,
	output lpht_pkg::ram_req_t                  ram_req,
	input  wire logic [lpht_pkg::KEY_WIDTH-1:0] ram_rdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [lpht_pkg::STATUS_W-1:0]       res_status,
	output logic [lpht_pkg::SLOT_W-1:0]         res_slot
);

	lpht_pkg::state_t               state_q, state_nxt;
	logic [lpht_pkg::TABLE_SIZE-1:0] vld_q;
	logic [lpht_pkg::CMD_W-1:0]      cmd_q;
	logic [lpht_pkg::KEY_WIDTH-1:0]  key_q;
	logic [lpht_pkg::IDX_W-1:0]      idx_q;
	logic [lpht_pkg::IDX_W-1:0]      cnt_q;
	lpht_pkg::status_t               stat_q;
	logic [lpht_pkg::IDX_W-1:0]      hit_q;
	logic                            out_valid_q;
	logic [lpht_pkg::STATUS_W-1:0]   out_status_q;
	logic [lpht_pkg::SLOT_W-1:0]     out_slot_q;

	logic                            accept;
	logic                            in_insert;
	logic                            in_scan;
	logic [lpht_pkg::KEY_WIDTH-1:0]  slot_key;
	logic                            is_insert;
	logic                            slot_empty;
	logic                            slot_hit;
	logic                            chk_finish;
	logic                            chk_fail;
	logic                            resp_load;
	logic [lpht_pkg::IDX_W-1:0]      idx_inc;

	assign accept    = s_tvalid && s_tready;
	assign in_insert = (cmd_in == lpht_pkg::CMD_INSERT);
	assign in_scan   = ((cmd_in == lpht_pkg::CMD_FIND) || (cmd_in == lpht_pkg::CMD_DELETE))
	                   && (key_in != '0);
	assign is_insert = (cmd_q == lpht_pkg::CMD_INSERT);

	assign slot_key   = vld_q[idx_q] ? ram_rdata : '0;
	assign slot_empty = (slot_key == '0);
	assign slot_hit   = (slot_key == key_q);
	assign idx_inc    = (idx_q == lpht_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;

	always_comb begin
		if (is_insert) begin
			chk_finish = slot_empty || (cnt_q == lpht_pkg::LAST_IDX);
			chk_fail   = !slot_empty;
		end else begin
			chk_finish = slot_hit || (idx_q == lpht_pkg::LAST_IDX);
			chk_fail   = !slot_hit;
		end
	end

	assign resp_load = (state_q == lpht_pkg::S_RESP) && (!out_valid_q || m_tready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lpht_pkg::S_IDLE: begin
				if (accept) begin
					if (in_insert) begin
						state_nxt = lpht_pkg::S_HASH;
					end else if (in_scan) begin
						state_nxt = lpht_pkg::S_READ;
					end else begin
						state_nxt = lpht_pkg::S_RESP;
					end
				end
			end
			lpht_pkg::S_HASH: begin
				if (hash_rsp.done) begin
					state_nxt = lpht_pkg::S_READ;
				end
			end
			lpht_pkg::S_READ: state_nxt = lpht_pkg::S_CHECK;
			lpht_pkg::S_CHECK: begin
				state_nxt = chk_finish ? lpht_pkg::S_RESP : lpht_pkg::S_READ;
			end
			lpht_pkg::S_RESP: begin
				if (resp_load) begin
					state_nxt = lpht_pkg::S_IDLE;
				end
			end
			default: state_nxt = lpht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == lpht_pkg::S_IDLE);
		hash_start    = (state_q == lpht_pkg::S_IDLE) && accept && in_insert;
		ram_req.re    = (state_q == lpht_pkg::S_READ);
		ram_req.we    = (state_q == lpht_pkg::S_CHECK) && is_insert && slot_empty;
		ram_req.addr  = idx_q;
		ram_req.wdata = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpht_pkg::S_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ram_req.we) begin
				vld_q[idx_q] <= 1'b1;
			end else if ((state_q == lpht_pkg::S_CHECK) && (cmd_q == lpht_pkg::CMD_DELETE)
			             && slot_hit) begin
				vld_q[idx_q] <= 1'b0;
			end
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lpht_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd_in;
					key_q  <= key_in;
					idx_q  <= '0;
					cnt_q  <= '0;
					stat_q <= lpht_pkg::STAT_MISSING;
					hit_q  <= '0;
				end
			end
			lpht_pkg::S_HASH: begin
				if (hash_rsp.done) begin
					idx_q <= lpht_pkg::IDX_W'(hash_rsp.rem);
				end
			end
			lpht_pkg::S_READ: ;
			lpht_pkg::S_CHECK: begin
				if (chk_finish) begin
					if (chk_fail) begin
						stat_q <= is_insert ? lpht_pkg::STAT_FULL : lpht_pkg::STAT_MISSING;
						hit_q  <= '0;
					end else begin
						stat_q <= lpht_pkg::STAT_DONE;
						hit_q  <= idx_q;
					end
				end else begin
					idx_q <= idx_inc;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			lpht_pkg::S_RESP: ;
			default: ;
		endcase
		if (resp_load) begin
			out_status_q <= stat_q;
			out_slot_q   <= lpht_pkg::SLOT_W'(hit_q);
		end
	end

	assign m_tvalid   = out_valid_q;
	assign res_status = out_status_q;
	assign res_slot   = out_slot_q;

endmodule
`default_nettype wire

// ===== design/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table: stream ports, slot RAM, remainder unit, sequencer.
// Depends on lpht_pkg, lpht_ram, lpht_hash and lpht_ctrl.
//
// Keeps TABLE_SIZE keys in a RAM with a registered read port; key 0 marks an empty slot and
// the table is empty after reset (per-slot occupancy flops, no clearing pass). Each word in
// gives exactly one word out. Insert first reduces the key mod TABLE_SIZE in a pipelined
// remainder unit (weighted byte fold, then reciprocal multiply), then probes upward with
// wraparound, each slot taking a RAM read, then a compare and write. Find and delete scan
// from slot 0, each slot taking a RAM read, then a compare. Find or delete of key 0 and the
// unused command go straight to the response. One command is processed at a time; a new
// word is taken while the previous result waits on the output register, and the next
// result is held back until that register drains.
`default_nettype none
module linear_probe_hash_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [lpht_pkg::S_DATA_W-1:0] s_tdata,  // command[1:0], key[33:2], zero fill
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [lpht_pkg::M_DATA_W-1:0] m_tdata   // status[1:0], slot_index[5:2], zero fill
);

	logic [lpht_pkg::CMD_W-1:0]     command;
	logic [lpht_pkg::KEY_WIDTH-1:0] key;
	logic                           hash_start;
	lpht_pkg::hash_rsp_t            hash_rsp;
	lpht_pkg::ram_req_t             ram_req;
	logic [lpht_pkg::KEY_WIDTH-1:0] ram_rdata;
	logic [lpht_pkg::STATUS_W-1:0]  status;
	logic [lpht_pkg::SLOT_W-1:0]    slot_index;

	assign command = s_tdata[lpht_pkg::CMD_W-1:0];
	assign key     = s_tdata[lpht_pkg::CMD_W +: lpht_pkg::KEY_WIDTH];

	lpht_ram #(
		.WIDTH(lpht_pkg::KEY_WIDTH),
		.DEPTH(lpht_pkg::TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.re   (ram_req.re),
		.addr (ram_req.addr),
		.wdata(ram_req.wdata),
		.rdata(ram_rdata)
	);

	lpht_hash u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (hash_start),
		.key   (key),
		.rsp   (hash_rsp)
	);

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.cmd_in    (command),
		.key_in    (key),
		.hash_start(hash_start),
		.hash_rsp  (hash_rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_status(status),
		.res_slot  (slot_index)
	);

	assign m_tdata = {(lpht_pkg::M_DATA_W - lpht_pkg::STATUS_W - lpht_pkg::SLOT_W)'(0),
	                  slot_index, status};

endmodule
`default_nettype wire
